@@ rtl/i2a_pkg.sv @@
// Package for the integer-to-ASCII formatter: item types, conversion kinds,
// sequencer states and character helpers. Depends on nothing.
package i2a_pkg;

  localparam int unsigned MaxWidth    = 63;
  localparam int unsigned BcdDigits   = 20;
  localparam int unsigned BcdW        = 4 * BcdDigits;
  localparam int unsigned IdxW        = $clog2(BcdDigits);
  localparam int unsigned DabbleSteps = 64;
  localparam int unsigned StepW       = $clog2(DabbleSteps);
  localparam int unsigned PtrDigits   = 16;

  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChLowerX  = 8'h78;
  localparam logic [7:0] ChMinus   = 8'h2d;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChUpperA  = 8'h41;
  localparam logic [7:0] ChLowerA  = 8'h61;

  typedef enum logic [2:0] {
    KIND_SDEC = 3'd0,
    KIND_UDEC = 3'd1,
    KIND_HEXL = 3'd2,
    KIND_HEXU = 3'd3,
    KIND_PTR  = 3'd4,
    KIND_CHAR = 3'd5,
    KIND_PCT  = 3'd6,
    KIND_RSVD = 3'd7
  } kind_e;

  typedef enum logic [1:0] {
    C_IDLE,
    C_DABBLE,
    C_SCAN
  } conv_state_e;

  typedef enum logic [3:0] {
    T_IDLE,
    T_CONV,
    T_SETUP,
    T_PFX0,
    T_PFX1,
    T_SIGN_PRE,
    T_FILL,
    T_SIGN_POST,
    T_DIGIT
  } top_state_e;

  typedef struct packed {
    logic [2:0]  conversion_kind;
    logic [63:0] value;
    logic        wide;
    logic        zero_pad;
    logic [5:0]  field_width;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_char;
  } out_item_t;

  typedef struct packed {
    logic        start;
    logic        hex;
    logic [63:0] mag;
  } conv_req_t;

  typedef struct packed {
    logic            done;
    logic [IdxW-1:0] len;
  } conv_sts_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] base;
    begin
      if (d < 4'd10) begin
        digit_char = ChZero + {4'b0000, d};
      end else begin
        base = upper ? ChUpperA : ChLowerA;
        digit_char = base + {4'b0000, d - 4'd10};
      end
    end
  endfunction

endpackage

@@ rtl/i2a_conv.sv @@
// Digit engine of the integer-to-ASCII formatter: shift-and-add-3 binary to BCD
// conversion, or a direct nibble load for hex, then a scan for the digit count.
// Depends on i2a_pkg.
module i2a_conv (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  i2a_pkg::conv_req_t        req_i,
  input  logic [i2a_pkg::IdxW-1:0]  rd_idx_i,
  output i2a_pkg::conv_sts_t        sts_o,
  output logic [3:0]                rd_digit_o
);
  import i2a_pkg::*;

  conv_state_e      state_q, state_d;
  logic [StepW-1:0] cnt_q, cnt_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic [63:0]      bin_q, bin_d;
  logic [BcdW-1:0]  bcd_q, bcd_d;
  logic [BcdW-1:0]  adj;
  logic [3:0]       scan_digit;
  logic             scan_end;

  always_comb begin
    for (int i = 0; i < BcdDigits; i++) begin
      adj[i*4 +: 4] = (bcd_q[i*4 +: 4] >= 4'd5) ? bcd_q[i*4 +: 4] + 4'd3 : bcd_q[i*4 +: 4];
    end
  end

  assign scan_digit = bcd_q[{idx_q, 2'b00} +: 4];
  assign rd_digit_o = bcd_q[{rd_idx_i, 2'b00} +: 4];
  assign scan_end   = (idx_q == '0) || (scan_digit != 4'd0);

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    idx_d      = idx_q;
    bin_d      = bin_q;
    bcd_d      = bcd_q;
    sts_o.done = 1'b0;
    sts_o.len  = idx_q + IdxW'(1);
    case (state_q)
      C_IDLE: begin
        if (req_i.start) begin
          idx_d = IdxW'(BcdDigits - 1);
          if (req_i.hex) begin
            bcd_d   = {{(BcdW - 64){1'b0}}, req_i.mag};
            state_d = C_SCAN;
          end else begin
            bin_d   = req_i.mag;
            bcd_d   = '0;
            cnt_d   = '0;
            state_d = C_DABBLE;
          end
        end
      end
      C_DABBLE: begin
        bcd_d = {adj[BcdW-2:0], bin_q[63]};
        bin_d = {bin_q[62:0], 1'b0};
        cnt_d = cnt_q + StepW'(1);
        if (cnt_q == StepW'(DabbleSteps - 1)) begin
          state_d = C_SCAN;
        end
      end
      C_SCAN: begin
        if (scan_end) begin
          sts_o.done = 1'b1;
          state_d    = C_IDLE;
        end else begin
          idx_d = idx_q - IdxW'(1);
        end
      end
      default: begin
        state_d = C_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      cnt_q   <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

endmodule

@@ rtl/integer_to_ascii_formatter_unit.sv @@
// Top level of the integer-to-ASCII formatter: request decode, padding and
// character sequencer with the output register. Depends on i2a_pkg and i2a_conv.
//
// One request item enters on the input channel when in_valid_i is high and
// in_stall_o is low; in_stall_o stays high until the last character of that
// request has been loaded into the output register. Each character leaves as
// one item on the output channel, with last_char set on the final one.
// Decimal kinds run 64 shift-and-add-3 steps, then a scan of up to 20 digits
// for the digit count; hex and pointer kinds skip the 64 steps. A set-up
// state follows, then one character per cycle while the receiver takes them.
// Character and percent kinds skip the digit engine and go straight to set-up.
// When out_stall_i is high with an item held valid, that item holds and the sequencer waits.
// Reset empties the output register and returns the sequencer to idle.
module integer_to_ascii_formatter_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  i2a_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output i2a_pkg::out_item_t out_item_o
);
  import i2a_pkg::*;

  top_state_e      state_q, state_d;
  logic            out_valid_q, out_valid_d;
  out_item_t       out_item_q, out_item_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [IdxW-1:0] len_q, len_d;
  logic [5:0]      fill_q, fill_d;
  logic [5:0]      width_q, width_d;
  logic            neg_q, neg_d;
  logic            zpad_q, zpad_d;
  logic            ptr_q, ptr_d;
  logic            raw_q, raw_d;
  logic            hex_q, hex_d;
  logic            upper_q, upper_d;
  logic [7:0]      char_q, char_d;

  conv_req_t   conv_req;
  conv_sts_t   conv_sts;
  logic [3:0]  rd_digit;
  kind_e       kind;
  logic [63:0] sval;
  logic [63:0] uval;
  logic [5:0]  lenneg;
  logic        accept;
  logic        adv;
  logic        emit;
  logic [7:0]  emit_char;
  logic        emit_last;

  i2a_conv u_conv (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (conv_req),
    .rd_idx_i   (idx_q),
    .sts_o      (conv_sts),
    .rd_digit_o (rd_digit)
  );

  assign in_stall_o  = (state_q != T_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign adv         = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;
  assign kind        = kind_e'(in_item_i.conversion_kind);
  assign sval        = in_item_i.wide ? in_item_i.value
                                      : {{32{in_item_i.value[31]}}, in_item_i.value[31:0]};
  assign uval        = in_item_i.wide ? in_item_i.value : {32'b0, in_item_i.value[31:0]};
  assign lenneg      = {1'b0, len_q} + {5'b0, neg_q};

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    len_d     = len_q;
    fill_d    = fill_q;
    width_d   = width_q;
    neg_d     = neg_q;
    zpad_d    = zpad_q;
    ptr_d     = ptr_q;
    raw_d     = raw_q;
    hex_d     = hex_q;
    upper_d   = upper_q;
    char_d    = char_q;
    conv_req  = '0;
    emit      = 1'b0;
    emit_char = ChSpace;
    emit_last = 1'b0;
    case (state_q)
      T_IDLE: begin
        if (accept) begin
          zpad_d  = in_item_i.zero_pad;
          width_d = (in_item_i.field_width > 6'(MaxWidth)) ? 6'(MaxWidth)
                                                           : in_item_i.field_width;
          neg_d   = 1'b0;
          ptr_d   = 1'b0;
          raw_d   = 1'b0;
          hex_d   = 1'b0;
          upper_d = 1'b0;
          char_d  = ChPercent;
          conv_req.start = 1'b1;
          state_d = T_CONV;
          case (kind)
            KIND_SDEC: begin
              neg_d        = sval[63];
              conv_req.mag = sval[63] ? 64'd0 - sval : sval;
            end
            KIND_UDEC: begin
              conv_req.mag = uval;
            end
            KIND_HEXL, KIND_HEXU: begin
              hex_d        = 1'b1;
              upper_d      = (kind == KIND_HEXU);
              conv_req.hex = 1'b1;
              conv_req.mag = uval;
            end
            KIND_PTR: begin
              hex_d        = 1'b1;
              ptr_d        = 1'b1;
              width_d      = '0;
              conv_req.hex = 1'b1;
              conv_req.mag = in_item_i.value;
            end
            KIND_CHAR: begin
              raw_d          = 1'b1;
              char_d         = in_item_i.value[7:0];
              len_d          = IdxW'(1);
              conv_req.start = 1'b0;
              state_d        = T_SETUP;
            end
            default: begin
              raw_d          = 1'b1;
              len_d          = IdxW'(1);
              conv_req.start = 1'b0;
              state_d        = T_SETUP;
            end
          endcase
        end
      end
      T_CONV: begin
        if (conv_sts.done) begin
          len_d   = ptr_q ? IdxW'(PtrDigits) : conv_sts.len;
          state_d = T_SETUP;
        end
      end
      T_SETUP: begin
        idx_d  = len_q - IdxW'(1);
        fill_d = (width_q > lenneg) ? width_q - lenneg : 6'd0;
        if (ptr_q) begin
          state_d = T_PFX0;
        end else if (zpad_q) begin
          state_d = neg_q ? T_SIGN_PRE : ((fill_d != '0) ? T_FILL : T_DIGIT);
        end else begin
          state_d = (fill_d != '0) ? T_FILL : (neg_q ? T_SIGN_POST : T_DIGIT);
        end
      end
      T_PFX0: begin
        emit_char = ChZero;
        if (adv) begin
          emit    = 1'b1;
          state_d = T_PFX1;
        end
      end
      T_PFX1: begin
        emit_char = ChLowerX;
        if (adv) begin
          emit    = 1'b1;
          state_d = T_DIGIT;
        end
      end
      T_SIGN_PRE: begin
        emit_char = ChMinus;
        if (adv) begin
          emit    = 1'b1;
          state_d = (fill_q != '0) ? T_FILL : T_DIGIT;
        end
      end
      T_FILL: begin
        emit_char = zpad_q ? ChZero : ChSpace;
        if (adv) begin
          emit   = 1'b1;
          fill_d = fill_q - 6'd1;
          if (fill_q == 6'd1) begin
            state_d = (!zpad_q && neg_q) ? T_SIGN_POST : T_DIGIT;
          end
        end
      end
      T_SIGN_POST: begin
        emit_char = ChMinus;
        if (adv) begin
          emit    = 1'b1;
          state_d = T_DIGIT;
        end
      end
      T_DIGIT: begin
        emit_char = raw_q ? char_q : digit_char(rd_digit, upper_q && hex_q);
        emit_last = (idx_q == '0);
        if (adv) begin
          emit  = 1'b1;
          idx_d = idx_q - IdxW'(1);
          if (idx_q == '0) begin
            state_d = T_IDLE;
          end
        end
      end
      default: begin
        state_d = T_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    out_item_d  = out_item_q;
    if (emit) begin
      out_valid_d          = 1'b1;
      out_item_d.out_char  = emit_char;
      out_item_d.last_char = emit_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      len_q       <= '0;
      fill_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
      len_q       <= len_d;
      fill_q      <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
    width_q    <= width_d;
    neg_q      <= neg_d;
    zpad_q     <= zpad_d;
    ptr_q      <= ptr_d;
    raw_q      <= raw_d;
    hex_q      <= hex_d;
    upper_q    <= upper_d;
    char_q     <= char_d;
  end

endmodule
